### src/ble_pkg.sv
package ble_pkg;

    // Default list capacity in entries
    localparam int DEFAULT_CAPACITY = 16;

    // Width of one stored entry
    localparam int DATA_W = 32;

    // Command codes
    localparam logic [2:0] CMD_ADD_FRONT = 3'd0;
    localparam logic [2:0] CMD_ADD_BACK  = 3'd1;
    localparam logic [2:0] CMD_REM_FRONT = 3'd2;
    localparam logic [2:0] CMD_REM_BACK  = 3'd3;
    localparam logic [2:0] CMD_REM_VALUE = 3'd4;
    localparam logic [2:0] CMD_CONTAINS  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_COMPARE,
        ENG_LOCATE,
        ENG_APPLY
    } engine_state_t;

    // Operation broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_PULL
    } cell_op_t;

    // Control broadcast from the sequencer to the cell row
    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

endpackage

### src/ble_cell.sv
module ble_cell
    import ble_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CW-1:0]     fill_count,
    input  logic              pull_en,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data,
    output logic              hit
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit_reg;
    logic              occupied;

    // Cell holds a live entry when its position is below the fill count
    assign occupied = CW'(INDEX) < fill_count;

    // Next entry value for the broadcast operation
    always_comb begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
                data_next = data_reg;
            end
            CELL_PUSH_FRONT: begin
                data_next = left_data;
            end
            CELL_PUSH_BACK: begin
                if (CW'(INDEX) == fill_count) begin
                    data_next = ctrl.value;
                end
            end
            CELL_PULL: begin
                if (pull_en) begin
                    data_next = right_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    // Entry storage and per-cell match flag
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        hit_reg  <= occupied && (data_reg == ctrl.value);
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

### src/bounded_list_engine.sv
// Bounded ordered list of signed 32-bit values, held as a row of CAPACITY
// cells with the front entry in cell 0. Commands add at the front or back,
// remove from the front or back, remove the first entry equal to a value,
// or test for a value; every command returns one result with the removed
// value, a status and the entry count afterwards. A command passes through
// the transfer in, a step in which every cell compares its entry against
// the command value, a step that finds the first match, and an update
// step that shifts the cells and loads the result register. A new command
// is taken as soon as the result is registered, while it still waits on
// m_ready; the update step holds only while the result register is full.
module bounded_list_engine
    import ble_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic [DATA_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_result_value,
    output logic [1:0]        m_status,
    output logic [CW-1:0]     m_entry_count
);

    localparam int IW = $clog2(CAPACITY);

    engine_state_t       state_reg, state_next;
    logic [2:0]          cmd_reg;
    logic [DATA_W-1:0]   value_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CAPACITY-1:0] match_mask_reg, match_mask_next;
    logic                found_reg, found_next;
    logic [DATA_W-1:0]   tail_reg, tail_next;

    logic                m_valid_reg;
    logic [DATA_W-1:0]   m_result_value_reg, m_result_value_next;
    logic [1:0]          m_status_reg, m_status_next;
    logic [CW-1:0]       m_entry_count_reg;

    cell_ctrl_t          ctrl;
    logic [CAPACITY-1:0] pull_mask;
    logic [CAPACITY-1:0] hits;
    logic [CAPACITY-1:0] first_hit;
    logic [DATA_W-1:0]   cell_data [CAPACITY];
    logic [CW-1:0]       count_dec;
    logic                list_empty;
    logic                list_full;
    logic                out_free;
    logic                in_xfer;
    logic                apply_go;

    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign count_dec  = count_reg - CW'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign in_xfer    = s_valid && s_ready;
    assign apply_go   = (state_reg == ENG_APPLY) && out_free;

    // Cell row: each cell takes its neighbor's entry on a shift
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0) begin : g_head
            assign left_d = value_reg;
        end else begin : g_body
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign right_d = cell_data[i];
        end else begin : g_inner
            assign right_d = cell_data[i+1];
        end

        ble_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .fill_count (count_reg),
            .pull_en    (pull_mask[i]),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .hit        (hits[i])
        );
    end

    // First match: isolate lowest hit, then mark it and every cell behind it
    assign first_hit       = hits & (~hits + CAPACITY'(1));
    assign match_mask_next = ~(first_hit - CAPACITY'(1));
    assign found_next      = |hits;
    assign tail_next       = cell_data[count_dec[IW-1:0]];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: begin
                if (in_xfer) begin
                    state_next = ENG_COMPARE;
                end
            end
            ENG_COMPARE: begin
                state_next = ENG_LOCATE;
            end
            ENG_LOCATE: begin
                state_next = ENG_APPLY;
            end
            ENG_APPLY: begin
                if (out_free) begin
                    state_next = ENG_IDLE;
                end
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    // Outputs of the update cycle: cell operation, new count and result
    always_comb begin
        ctrl.op             = CELL_HOLD;
        ctrl.value          = value_reg;
        pull_mask           = '1;
        count_next          = count_reg;
        m_result_value_next = '0;
        m_status_next       = ST_OK;
        if (state_reg == ENG_APPLY) begin
            unique case (cmd_reg)
                CMD_ADD_FRONT, CMD_ADD_BACK: begin
                    if (list_full) begin
                        m_status_next = ST_FULL;
                    end else begin
                        ctrl.op    = (cmd_reg == CMD_ADD_FRONT) ? CELL_PUSH_FRONT
                                                                 : CELL_PUSH_BACK;
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_REM_FRONT: begin
                    if (list_empty) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        ctrl.op             = CELL_PULL;
                        m_result_value_next = cell_data[0];
                        count_next          = count_dec;
                    end
                end
                CMD_REM_BACK: begin
                    if (list_empty) begin
                        m_status_next = ST_EMPTY;
                    end else begin
                        m_result_value_next = tail_reg;
                        count_next          = count_dec;
                    end
                end
                CMD_REM_VALUE: begin
                    if (list_empty) begin
                        m_status_next = ST_EMPTY;
                    end else if (!found_reg) begin
                        m_status_next = ST_MISSING;
                    end else begin
                        ctrl.op    = CELL_PULL;
                        pull_mask  = match_mask_reg;
                        count_next = count_dec;
                    end
                end
                CMD_CONTAINS: begin
                    m_status_next = found_reg ? ST_OK : ST_MISSING;
                end
                default: begin
                    m_status_next = ST_OK;
                end
            endcase
            if (!out_free) begin
                ctrl.op    = CELL_HOLD;
                count_next = count_reg;
            end
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ENG_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (apply_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command, search and result payload
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            cmd_reg   <= s_command;
            value_reg <= s_value;
        end
        if (state_reg == ENG_LOCATE) begin
            match_mask_reg <= match_mask_next;
            found_reg      <= found_next;
            tail_reg       <= tail_next;
        end
        if (apply_go) begin
            m_result_value_reg <= m_result_value_next;
            m_status_reg       <= m_status_next;
            m_entry_count_reg  <= count_next;
        end
    end

    assign s_ready        = (state_reg == ENG_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_status       = m_status_reg;
    assign m_entry_count  = m_entry_count_reg;

    // Count stays within the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A transfer in starts the compare cycle
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg == ENG_COMPARE)
        else $error("command did not start compare");

    // A result appears only out of the update cycle
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ENG_APPLY)
        else $error("result raised outside update cycle");

    // Count changes only in a committed update
    a_count_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> $past(apply_go))
        else $error("count changed outside update");

    // A refused add reports a full list
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_FULL) |->
            m_entry_count_reg == CW'(CAPACITY))
        else $error("full status with list not full");

endmodule

### tb/testbench.sv
module testbench
    import ble_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_W        = $clog2(DEFAULT_CAPACITY + 1);
    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_TAIL    = 120;
    localparam int STALL_LIMIT  = 2000;
    localparam int N_DIRECTED   = 25;

    // Codes 6 and 7 are not in the package; the engine treats them as no-ops
    localparam logic [2:0] CMD_NOP_6 = 3'd6;
    localparam logic [2:0] CMD_NOP_7 = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [1:0]        status;
        logic [CNT_W-1:0]  count;
    } list_reply_t;

    // One command as driven, with an optional hand-written reply
    typedef struct packed {
        logic [2:0]        cmd;
        logic [DATA_W-1:0] value;
        bit                typed;
        list_reply_t       reply;
    } cmd_row_t;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [2:0]        s_command      = CMD_ADD_FRONT;
    logic [DATA_W-1:0] s_value        = '0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [DATA_W-1:0] m_result_value;
    logic [1:0]        m_status;
    logic [CNT_W-1:0]  m_entry_count;

    // Shadow list, front entry at index 0
    logic [DATA_W-1:0] held_entries[$];
    list_reply_t       awaited_results[$];
    cmd_row_t          driven_rows[$];

    int mismatches = 0;
    int idle_pct   = 0;
    bit calm       = 1'b0;
    int sink_hold  = 0;
    int quiet_cycles = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int commands_seen = 0;
    int noops_seen    = 0;
    int peak_fill     = 0;

    // Directed opening: empty-list refusals, extremes, no-op codes, duplicates
    cmd_row_t directed_rows[N_DIRECTED] = '{
        '{CMD_REM_FRONT, 32'h5A5A5A5A, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{CMD_REM_BACK,  32'hA5A5A5A5, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{CMD_REM_VALUE, 32'h00000000, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{CMD_CONTAINS,  32'h00000000, 1'b1, '{32'h0, ST_MISSING, 5'd0}},
        '{CMD_NOP_6,     32'hFFFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd0}},
        '{CMD_ADD_FRONT, 32'h80000000, 1'b1, '{32'h0, ST_OK, 5'd1}},
        '{CMD_ADD_BACK,  32'h7FFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd2}},
        '{CMD_ADD_FRONT, 32'hFFFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd3}},
        '{CMD_ADD_BACK,  32'hFFFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd4}},
        '{CMD_CONTAINS,  32'h7FFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd4}},
        '{CMD_CONTAINS,  32'h7FFFFFFE, 1'b1, '{32'h0, ST_MISSING, 5'd4}},
        '{CMD_REM_VALUE, 32'h00000000, 1'b1, '{32'h0, ST_MISSING, 5'd4}},
        '{CMD_NOP_7,     32'h12345678, 1'b1, '{32'h0, ST_OK, 5'd4}},
        '{CMD_REM_VALUE, 32'hFFFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd3}},
        '{CMD_REM_FRONT, 32'h00000000, 1'b1, '{32'h80000000, ST_OK, 5'd2}},
        // only the front copy of -1 went away, so the back one is still here
        '{CMD_REM_BACK,  32'h00000000, 1'b1, '{32'hFFFFFFFF, ST_OK, 5'd1}},
        '{CMD_ADD_FRONT, 32'h00000000, 1'b1, '{32'h0, ST_OK, 5'd2}},
        '{CMD_ADD_BACK,  32'h00000000, 1'b1, '{32'h0, ST_OK, 5'd3}},
        '{CMD_REM_VALUE, 32'h00000000, 1'b1, '{32'h0, ST_OK, 5'd2}},
        '{CMD_REM_BACK,  32'hFFFFFFFF, 1'b1, '{32'h0, ST_OK, 5'd1}},
        '{CMD_REM_FRONT, 32'hFFFFFFFF, 1'b1, '{32'h7FFFFFFF, ST_OK, 5'd0}},
        '{CMD_REM_BACK,  32'h00000000, 1'b1, '{32'h0, ST_EMPTY, 5'd0}},
        '{CMD_CONTAINS,  32'h80000000, 1'b1, '{32'h0, ST_MISSING, 5'd0}},
        '{CMD_ADD_BACK,  32'h12345678, 1'b0, '{32'h0, ST_OK, 5'd0}},
        '{CMD_ADD_FRONT, 32'hA5A5A5A5, 1'b0, '{32'h0, ST_OK, 5'd0}}
    };

    bounded_list_engine DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_status       (m_status),
        .m_entry_count  (m_entry_count)
    );

    always #10 aclk = ~aclk;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Apply one command to the shadow list and return the reply it produces
    function automatic list_reply_t apply_list_command(logic [2:0] cmd,
                                                       logic [DATA_W-1:0] v);
        list_reply_t r;
        int pos;
        r.result_value = '0;
        r.status = ST_OK;
        pos = -1;
        case (cmd)
            CMD_ADD_FRONT, CMD_ADD_BACK: begin
                if (held_entries.size() >= DEFAULT_CAPACITY)
                    r.status = ST_FULL;
                else if (cmd == CMD_ADD_FRONT)
                    held_entries.push_front(v);
                else
                    held_entries.push_back(v);
            end
            CMD_REM_FRONT: begin
                if (held_entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.result_value = held_entries.pop_front();
            end
            CMD_REM_BACK: begin
                if (held_entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.result_value = held_entries.pop_back();
            end
            CMD_REM_VALUE, CMD_CONTAINS: begin
                // first match counted from the front
                foreach (held_entries[i])
                    if (pos < 0 && held_entries[i] == v)
                        pos = i;
                if (cmd == CMD_REM_VALUE && held_entries.size() == 0)
                    r.status = ST_EMPTY;
                else if (pos < 0)
                    r.status = ST_MISSING;
                else if (cmd == CMD_REM_VALUE)
                    held_entries.delete(pos);
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(held_entries.size());
        if (held_entries.size() > peak_fill)
            peak_fill = held_entries.size();
        return r;
    endfunction

    // Values biased toward entries already held, small duplicates and extremes
    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35 && held_entries.size() > 0)
            return held_entries[$urandom_range(0, held_entries.size() - 1)];
        if (roll < 60)
            return DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
        if (roll < 75) begin
            case ($urandom_range(0, 4))
                0: return 32'h80000000;
                1: return 32'h7FFFFFFF;
                2: return 32'hFFFFFFFF;
                3: return 32'h00000001;
                default: return 32'h00000000;
            endcase
        end
        return $urandom();
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Present one command after an optional gap and hold it until the transfer
    task automatic drive_command(cmd_row_t row, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= row.cmd;
        s_value   <= row.value;
        driven_rows.push_back(row);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result sink: random stall bursts
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            m_ready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            sink_hold <= $urandom_range(0, 18);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Predict on each command transfer, check on each result transfer
    always @(posedge aclk) begin : monitor
        cmd_row_t    row;
        list_reply_t want;
        list_reply_t seen;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                row  = driven_rows.pop_front();
                want = apply_list_command(row.cmd, row.value);
                if (row.typed)
                    want = row.reply;
                awaited_results.push_back(want);
                status_seen[want.status]++;
                commands_seen++;
                if (row.cmd == CMD_NOP_6 || row.cmd == CMD_NOP_7)
                    noops_seen++;
            end
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t ns: result with nothing expected: value %h status %0d count %0d",
                             $time, m_result_value, m_status, m_entry_count);
                    mismatches++;
                end else begin
                    seen = awaited_results.pop_front();
                    check_field("result_value", seen.result_value, m_result_value);
                    check_field("status", DATA_W'(seen.status), DATA_W'(m_status));
                    check_field("entry_count", DATA_W'(seen.count), DATA_W'(m_entry_count));
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, awaited_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus: directed table, then phases that fill, drain or mix the list
    initial begin
        cmd_row_t   row;
        logic [2:0] cmd;
        int counted;
        int phase;
        int len;
        int mode;
        int add_pct;
        int roll;
        int gap;
        counted = 0;
        phase   = 0;
        do @(posedge aclk); while (!aresetn);

        idle_pct = 10;
        for (int n = 0; n < N_DIRECTED; n++) begin
            gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 19) : 0;
            drive_command(directed_rows[n], gap);
        end

        while (counted < RANDOM_ITEMS) begin
            mode = (phase < 2) ? phase : $urandom_range(0, 2);
            case (mode)
                0: add_pct = 70;
                1: add_pct = 20;
                default: add_pct = 45;
            endcase
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 8;
                default: idle_pct = 30;
            endcase
            len = $urandom_range(20, 60);
            for (int k = 0; k < len && counted < RANDOM_ITEMS; k++) begin
                if (counted >= RANDOM_ITEMS - CALM_TAIL) begin
                    calm     = 1'b1;
                    idle_pct = 0;
                end
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    cmd = $urandom_range(0, 1) ? CMD_NOP_7 : CMD_NOP_6;
                else if (roll < 2 + add_pct)
                    cmd = $urandom_range(0, 1) ? CMD_ADD_BACK : CMD_ADD_FRONT;
                else
                    cmd = 3'($urandom_range(CMD_REM_FRONT, CMD_CONTAINS));
                row.cmd   = cmd;
                row.value = pick_value();
                row.typed = 1'b0;
                row.reply = '0;
                gap = (!calm && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 19) : 0;
                drive_command(row, gap);
                if (cmd != CMD_NOP_6 && cmd != CMD_NOP_7)
                    counted++;
            end
            phase++;
        end
        s_valid <= 1'b0;

        // drain the outstanding results, then idle before reporting
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Ran %0d commands (%0d no-op codes): ok %0d, empty %0d, full %0d, missing %0d",
                 commands_seen, noops_seen, status_seen[ST_OK], status_seen[ST_EMPTY],
                 status_seen[ST_FULL], status_seen[ST_MISSING]);
        $display("List reached %0d of %0d entries; %0d field mismatches",
                 peak_fill, DEFAULT_CAPACITY, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
